[hdl/htw_pkg.sv]
package htw_pkg;

	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_ARM    = 2'd1;
	localparam logic [1:0] KIND_CANCEL = 2'd2;

	localparam logic RES_EXPIRY = 1'b0;
	localparam logic RES_DONE   = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  timer_id;
		logic [19:0] period_ticks;
		logic        fire_now;
	} in_word_t;

	typedef struct packed {
		logic       result_kind;
		logic [3:0] fired_id;
		logic       last;
	} out_word_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic cancel;
		logic div_run;
		logic arm_wr;
		logic scan_run;
		logic emit_fire;
		logic emit_done;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_tick;
		logic in_arm;
		logic in_cancel;
		logic fire_now;
		logic div_done;
		logic scan_done;
		logic out_free;
	} ctl_sts_t;

endpackage

[hdl/hashed_timing_wheel.sv]
// Tick: one timer entry is read per cycle unless an expiry waits on a stalled
//   output, and each entry is updated or fired from its registered read.
// Arm: a reciprocal multiply for the quotient and then the remainder split the
//   period. Cancel and unused kinds go straight to the done word.
// One word at a time; results leave through a one-word output register, so a new
//   word is taken while it waits. Reset clears slot pointer, armed flags, control.
module hashed_timing_wheel #(
	parameter int TIMERS      = 16,
	parameter int WHEEL_SLOTS = 64,
	parameter int PERIOD_BITS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  htw_pkg::in_word_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output htw_pkg::out_word_t result
);
	import htw_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	htw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	htw_datapath #(
		.TIMERS      (TIMERS),
		.WHEEL_SLOTS (WHEEL_SLOTS),
		.PERIOD_BITS (PERIOD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

[hdl/htw_datapath.sv]
module htw_datapath #(
	parameter int TIMERS      = 16,
	parameter int WHEEL_SLOTS = 64,
	parameter int PERIOD_BITS = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  htw_pkg::in_word_t item,
	input  htw_pkg::ctl_cmd_t cmd,
	output htw_pkg::ctl_sts_t sts,
	input  logic              result_stall,
	output logic              result_valid,
	output htw_pkg::out_word_t result
);
	import htw_pkg::*;

	localparam int IDX_BITS     = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int CNT_BITS     = $clog2(TIMERS + 1);
	localparam int SLOT_BITS    = $clog2(WHEEL_SLOTS);
	localparam longint unsigned PMAX = (64'd1 << PERIOD_BITS) - 64'd1;
	localparam longint unsigned QMAX = PMAX / WHEEL_SLOTS;
	localparam int ROUND_BITS   = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
	localparam int DIV_SHIFT    = PERIOD_BITS + SLOT_BITS;
	localparam int PROD_BITS    = DIV_SHIFT + ROUND_BITS;
	// ceil(2^DIV_SHIFT / WHEEL_SLOTS) gives the exact quotient for every period
	localparam longint unsigned RECIP =
		((64'd1 << DIV_SHIFT) + 64'(WHEEL_SLOTS) - 64'd1) / 64'(WHEEL_SLOTS);

	localparam logic [SLOT_BITS:0]    SLOTS_W  = WHEEL_SLOTS[SLOT_BITS:0];
	localparam logic [SLOT_BITS-1:0]  SLOTS_LO = SLOT_BITS'(WHEEL_SLOTS);
	localparam logic [CNT_BITS-1:0]   TIMERS_C = TIMERS[CNT_BITS-1:0];
	localparam logic [PERIOD_BITS:0]  RECIP_W  = RECIP[PERIOD_BITS:0];
	localparam logic [1:0]            DIV_STEPS = 2'd2;

	typedef struct packed {
		logic [SLOT_BITS-1:0]  home;
		logic [ROUND_BITS-1:0] rounds;
		logic [ROUND_BITS-1:0] quot;
		logic [SLOT_BITS-1:0]  rem;
	} entry_t;

	// (a + b) mod WHEEL_SLOTS, both operands already below WHEEL_SLOTS
	function automatic logic [SLOT_BITS-1:0] slot_add(input logic [SLOT_BITS-1:0] a,
			input logic [SLOT_BITS-1:0] b);
		logic [SLOT_BITS:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= SLOTS_W) begin
			sum = sum - SLOTS_W;
		end
		return sum[SLOT_BITS-1:0];
	endfunction

	entry_t                    mem [TIMERS];
	entry_t                    rd_s1;
	logic [TIMERS-1:0]         armed_q;
	logic [SLOT_BITS-1:0]      cur_slot_q;
	logic [IDX_BITS-1:0]       id_q;
	logic                      fire_q;

	logic [PERIOD_BITS-1:0]    p_q;
	logic [ROUND_BITS-1:0]     quo_q;
	logic [SLOT_BITS-1:0]      rem_q;
	logic [1:0]                div_step_q;
	logic [PROD_BITS-1:0]      prod;
	logic [ROUND_BITS-1:0]     quo_nx;
	logic [SLOT_BITS-1:0]      rem_nx;

	logic [CNT_BITS-1:0]       scan_cnt_q;
	logic                      v_s1;
	logic [IDX_BITS-1:0]       idx_s1;

	logic [IDX_BITS-1:0]       in_idx;
	logic                      id_ok;
	logic                      out_free;
	logic                      hit;
	logic                      need_emit;
	logic                      stage_adv;
	logic                      can_issue;
	logic                      scan_emit;
	logic                      scan_wr;
	entry_t                    arm_entry;
	entry_t                    scan_entry;

	assign in_idx   = IDX_BITS'(item.timer_id);
	assign id_ok    = 32'(item.timer_id) < TIMERS;
	assign out_free = !result_valid || !result_stall;

	assign sts.in_tick   = item.kind == KIND_TICK;
	assign sts.in_arm    = (item.kind == KIND_ARM) && id_ok;
	assign sts.in_cancel = (item.kind == KIND_CANCEL) && id_ok;
	assign sts.fire_now  = fire_q;
	assign sts.div_done  = div_step_q == DIV_STEPS;
	assign sts.scan_done = (scan_cnt_q == TIMERS_C) && !v_s1;
	assign sts.out_free  = out_free;

	// quotient by reciprocal multiply, remainder from the low bits in the next division step
	assign prod   = PROD_BITS'(p_q) * PROD_BITS'(RECIP_W);
	assign quo_nx = prod[DIV_SHIFT +: ROUND_BITS];
	assign rem_nx = SLOT_BITS'(p_q) - SLOT_BITS'(SLOT_BITS'(quo_q) * SLOTS_LO);

	always_comb begin
		arm_entry.rem    = rem_q;
		arm_entry.quot   = quo_q;
		arm_entry.rounds = quo_q;
		arm_entry.home   = slot_add(cur_slot_q, rem_q);
	end

	// scan evaluation on the registered entry
	assign hit       = v_s1 && armed_q[idx_s1] && (rd_s1.home == cur_slot_q);
	assign need_emit = hit && (rd_s1.rounds == '0);
	assign stage_adv = cmd.scan_run && v_s1 && (!need_emit || out_free);
	assign can_issue = cmd.scan_run && (scan_cnt_q != TIMERS_C) && (!v_s1 || stage_adv);
	assign scan_emit = stage_adv && need_emit;
	assign scan_wr   = stage_adv && hit;

	always_comb begin
		scan_entry = rd_s1;
		if (need_emit) begin
			scan_entry.rounds = rd_s1.quot;
			scan_entry.home   = slot_add(cur_slot_q, rd_s1.rem);
		end else begin
			scan_entry.rounds = rd_s1.rounds - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.arm_wr) begin
			mem[id_q] <= arm_entry;
		end else if (scan_wr) begin
			mem[idx_s1] <= scan_entry;
		end
		if (can_issue) begin
			rd_s1 <= mem[scan_cnt_q[IDX_BITS-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q    <= '0;
			cur_slot_q <= '0;
			div_step_q <= '0;
			scan_cnt_q <= '0;
			v_s1       <= 1'b0;
		end else begin
			if (cmd.load) begin
				div_step_q <= '0;
				scan_cnt_q <= '0;
				v_s1       <= 1'b0;
				if (sts.in_tick) begin
					cur_slot_q <= slot_add(cur_slot_q, SLOT_BITS'(1));
				end
				if (cmd.cancel) begin
					armed_q[in_idx] <= 1'b0;
				end
			end else begin
				if (cmd.div_run) begin
					div_step_q <= div_step_q + 1'b1;
				end
				if (cmd.arm_wr) begin
					armed_q[id_q] <= 1'b1;
				end
				if (can_issue) begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
					v_s1       <= 1'b1;
				end else if (stage_adv) begin
					v_s1 <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q   <= in_idx;
			fire_q <= item.fire_now;
			p_q    <= PERIOD_BITS'(item.period_ticks);
		end else if (cmd.div_run) begin
			if (div_step_q == '0) begin
				quo_q <= quo_nx;
			end else begin
				rem_q <= rem_nx;
			end
		end
		if (can_issue) begin
			idx_s1 <= scan_cnt_q[IDX_BITS-1:0];
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (scan_emit || cmd.emit_fire || cmd.emit_done) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		priority if (scan_emit) begin
			result <= '{result_kind: RES_EXPIRY, fired_id: 4'(idx_s1), last: 1'b0};
		end else if (cmd.emit_fire) begin
			result <= '{result_kind: RES_EXPIRY, fired_id: 4'(id_q), last: 1'b0};
		end else if (cmd.emit_done) begin
			result <= '{result_kind: RES_DONE, fired_id: 4'd0, last: 1'b1};
		end
	end

endmodule

[hdl/htw_ctrl.sv]
module htw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  htw_pkg::ctl_sts_t sts,
	output htw_pkg::ctl_cmd_t cmd
);
	import htw_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_ARM  = 3'd2;
	localparam logic [2:0] ST_FIRE = 3'd3;
	localparam logic [2:0] ST_SCAN = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	assign item_stall = state_q != ST_IDLE;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					priority if (sts.in_tick) begin
						state_nx = ST_SCAN;
					end else if (sts.in_arm) begin
						state_nx = ST_DIV;
					end else begin
						cmd.cancel = sts.in_cancel;
						state_nx   = ST_DONE;
					end
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_nx = ST_ARM;
				end else begin
					cmd.div_run = 1'b1;
				end
			end
			ST_ARM: begin
				cmd.arm_wr = 1'b1;
				state_nx   = sts.fire_now ? ST_FIRE : ST_DONE;
			end
			ST_FIRE: begin
				if (sts.out_free) begin
					cmd.emit_fire = 1'b1;
					state_nx      = ST_DONE;
				end
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit_done = 1'b1;
					state_nx      = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

[hdl/htw_checker.sv]
module htw_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input htw_pkg::in_word_t  item,
	input logic               result_valid,
	input logic               result_stall,
	input htw_pkg::out_word_t result
);
	import htw_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed");

	a_last_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.last == (result.result_kind == RES_DONE)))
		else $error("last flag does not match done word");

	a_done_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.result_kind == RES_DONE |-> result.fired_id == 4'd0)
		else $error("done word carries a timer id");

	// once a word is taken the block is busy until its done word is queued
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input taken again right after acceptance");

	// an idle block can only be holding a done word
	a_idle_holds_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !item_stall |-> result.result_kind == RES_DONE)
		else $error("expiry word pending while idle");

endmodule

bind hashed_timing_wheel htw_checker u_htw_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import htw_pkg::*;

	localparam int TIMERS         = 16;
	localparam int WHEEL_SLOTS    = 64;
	localparam int PERIOD_BITS    = 20;
	localparam int SLOT_W         = $clog2(WHEEL_SLOTS);
	localparam int LAP_W          = PERIOD_BITS - SLOT_W;
	localparam int IN_BITS        = $bits(in_word_t);
	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int MAX_REPORTS    = 100;

	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      item_valid;
	logic      item_stall;
	in_word_t  item;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_word_t result;

	// wheel model
	logic [SLOT_W-1:0]      wheel_slot = '0;
	bit                     timer_on [TIMERS];
	logic [PERIOD_BITS-1:0] timer_len [TIMERS];
	logic [SLOT_W-1:0]      timer_home [TIMERS];
	logic [LAP_W-1:0]       timer_laps [TIMERS];

	out_word_t expected_results[$];
	int        mismatches = 0;
	bit        tx_gaps = 1'b1;
	bit        rx_gaps = 1'b1;
	int        rx_hold = 0;
	int        quiet_cycles = 0;

	hashed_timing_wheel uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic void push_result(logic kind, int id, logic last);
		out_word_t r;
		r.result_kind = kind;
		r.fired_id    = 4'(id);
		r.last        = last;
		expected_results.push_back(r);
	endfunction

	function automatic void place_timer(int id);
		timer_laps[id] = LAP_W'(timer_len[id] / WHEEL_SLOTS);
		timer_home[id] = SLOT_W'((wheel_slot + timer_len[id]) % WHEEL_SLOTS);
	endfunction

	function automatic void predict_word(in_word_t w);
		int id;
		id = int'(w.timer_id);
		case (w.kind)
			KIND_TICK: begin
				wheel_slot = SLOT_W'((wheel_slot + 1) % WHEEL_SLOTS);
				// each timer is visited once, even if re-armed into this slot
				for (int i = 0; i < TIMERS; i++) begin
					if (timer_on[i] && timer_home[i] == wheel_slot) begin
						if (timer_laps[i] != 0) begin
							timer_laps[i]--;
						end else begin
							push_result(RES_EXPIRY, i, 1'b0);
							place_timer(i);
						end
					end
				end
			end
			KIND_ARM: begin
				if (id < TIMERS) begin
					timer_len[id] = w.period_ticks[PERIOD_BITS-1:0];
					timer_on[id]  = 1'b1;
					place_timer(id);
					if (w.fire_now) begin
						push_result(RES_EXPIRY, id, 1'b0);
						place_timer(id);
					end
				end
			end
			KIND_CANCEL: begin
				if (id < TIMERS)
					timer_on[id] = 1'b0;
			end
			default: ;
		endcase
		push_result(RES_DONE, 0, 1'b1);
	endfunction

	function automatic in_word_t word_of(logic [1:0] kind, logic [3:0] id,
			logic [19:0] period, logic fire);
		in_word_t w;
		w.kind         = kind;
		w.timer_id     = id;
		w.period_ticks = period;
		w.fire_now     = fire;
		return w;
	endfunction

	// mostly short periods so timers actually expire; some long and full-range
	function automatic in_word_t random_word();
		in_word_t w;
		int       pick;
		int       span;
		w    = IN_BITS'($urandom);
		pick = $urandom_range(0, 99);
		span = $urandom_range(0, 99);
		if (pick < 55)
			w.kind = KIND_TICK;
		else if (pick < 82)
			w.kind = KIND_ARM;
		else if (pick < 94)
			w.kind = KIND_CANCEL;
		else
			w.kind = KIND_UNUSED;
		if (span < 55)
			w.period_ticks = 20'($urandom_range(0, 12));
		else if (span < 85)
			w.period_ticks = 20'($urandom_range(0, 300));
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: mismatch: %s", $time, msg);
	endtask

	task automatic check_result(input out_word_t got);
		out_word_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("unexpected word kind=%0d id=%0d last=%0d",
				got.result_kind, got.fired_id, got.last));
			return;
		end
		want = expected_results.pop_front();
		if (got.result_kind !== want.result_kind)
			report_mismatch($sformatf("result_kind %0d, expected %0d",
				got.result_kind, want.result_kind));
		if (got.fired_id !== want.fired_id)
			report_mismatch($sformatf("fired_id %0d, expected %0d",
				got.fired_id, want.fired_id));
		if (got.last !== want.last)
			report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
	endtask

	task automatic send_word(input in_word_t w);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall !== 1'b0);
		predict_word(w);
	endtask

	// output side: random stall after each accepted word while rx_gaps is set
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			check_result(result);
			rx_hold = rx_gaps ? $urandom_range(0, 8) : 0;
		end else if (rx_hold > 0) begin
			rx_hold--;
		end
		result_stall <= (rx_hold != 0);
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	task automatic test_arm_fire_cancel();
		send_word(word_of(KIND_TICK, 4'd0, 20'd0, 1'b0));
		send_word(word_of(KIND_ARM, 4'd0, 20'd0, 1'b1));
		// junk in the unused fields of a tick
		send_word(word_of(KIND_TICK, 4'hF, 20'hFFFFF, 1'b1));
		send_word(word_of(KIND_ARM, 4'd15, 20'd1, 1'b0));
		send_word(word_of(KIND_ARM, 4'd5, 20'hFFFFF, 1'b1));
		send_word(word_of(KIND_ARM, 4'd7, 20'd2, 1'b1));
		send_word(word_of(KIND_ARM, 4'd7, 20'd3, 1'b0));
		repeat (3) send_word(word_of(KIND_TICK, 4'd0, 20'd0, 1'b0));
		send_word(word_of(KIND_CANCEL, 4'd0, 20'd0, 1'b0));
		send_word(word_of(KIND_CANCEL, 4'd12, 20'hABCDE, 1'b1));
		send_word(word_of(KIND_UNUSED, 4'hA, 20'h5A5A5, 1'b1));
		send_word(word_of(KIND_TICK, 4'd0, 20'd0, 1'b0));
	endtask

	// every timer expiring on the same tick gives the longest burst
	task automatic test_full_tick();
		for (int i = 0; i < TIMERS; i++)
			send_word(word_of(KIND_ARM, 4'(i), 20'd1, 1'($urandom_range(0, 1))));
		repeat (2) send_word(word_of(KIND_TICK, 4'd0, 20'd0, 1'b0));
	endtask

	// periods on both sides of one wheel turn, no idling on either side
	task automatic test_round_countdown();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		for (int i = 0; i < TIMERS; i++)
			send_word(word_of(KIND_ARM, 4'(i), 20'(40 + 4 * i), 1'b0));
		repeat (70) send_word(word_of(KIND_TICK, 4'd0, 20'd0, 1'b0));
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	task automatic test_random_mix();
		in_word_t w;
		int       counted;
		counted = 0;
		while (counted < 300) begin
			if (counted % 50 == 0) begin
				tx_gaps = $urandom_range(0, 1);
				rx_gaps = $urandom_range(0, 1);
			end
			w = random_word();
			send_word(w);
			if (w.kind != KIND_UNUSED)
				counted++;
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		for (int i = 0; i < TIMERS; i++)
			timer_on[i] = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_arm_fire_cancel();
		test_full_tick();
		test_round_countdown();
		test_random_mix();

		item_valid <= 1'b0;
		rx_gaps = 1'b1;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
